>>> hdl/cbe_pkg.sv
package cbe_pkg;

  localparam int unsigned CoordW      = 16;
  localparam int unsigned PointW      = 3 * CoordW;
  localparam int unsigned NumPoints   = 4;
  localparam int unsigned CfgIdxW     = 2;
  localparam int unsigned TW          = 16;
  localparam int unsigned IndexW      = 6;
  localparam int unsigned DistW       = 34;
  localparam int unsigned SampleCount = 64;

  localparam logic REQ_EVAL    = 1'b0;
  localparam logic REQ_PROJECT = 1'b1;

  typedef struct packed {
    logic                     req_type;
    logic [TW-1:0]            t_param;
    logic signed [CoordW-1:0] pos_x;
    logic signed [CoordW-1:0] pos_y;
    logic signed [CoordW-1:0] pos_z;
  } req_t;

  typedef struct packed {
    logic signed [CoordW-1:0] out_x;
    logic signed [CoordW-1:0] out_y;
    logic signed [CoordW-1:0] out_z;
    logic [IndexW-1:0]        sample_index;
    logic [DistW-1:0]         distance_sq;
  } res_t;

  // start/done pair between the sequencer and the shared evaluator
  typedef struct packed {
    logic          start;
    logic [TW-1:0] t;
  } eval_cmd_t;

  typedef struct packed {
    logic                     done;
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
  } eval_rsp_t;

endpackage

>>> hdl/cbe_stream_if.sv
interface cbe_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hdl/cbe_ram.sv
module cbe_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

>>> hdl/cbe_eval.sv
// Multi-cycle curve evaluator: one 32x32-class multiply a cycle, axis by axis.
module cbe_eval
  import cbe_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [PointW-1:0]       p0_i,
  input  logic [PointW-1:0]       p1_i,
  input  logic [PointW-1:0]       p2_i,
  input  logic [PointW-1:0]       p3_i,
  input  eval_cmd_t               cmd_i,
  output eval_rsp_t               rsp_o
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_M1   = 3'd1;
  localparam logic [2:0] S_M2   = 3'd2;
  localparam logic [2:0] S_M3   = 3'd3;
  localparam logic [2:0] S_M4   = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0] state_q, state_d;
  logic [1:0] axis_q, axis_d;
  logic [TW-1:0] t_q;
  logic signed [19:0] a_q, b_q, c_q;
  logic signed [15:0] d_q;
  logic signed [55:0] acc_q, acc_d;
  logic [15:0] lo_q, lo_d;
  logic signed [CoordW-1:0] res_q [3];
  logic signed [CoordW-1:0] res_d [3];

  logic signed [15:0] e0, e1, e2, e3;
  logic signed [19:0] ca, cb, cc;
  logic signed [16:0] ts;
  logic signed [55:0] r;

  always_comb begin
    unique case (axis_d)
      2'd1:    begin
        e0 = p0_i[31:16]; e1 = p1_i[31:16]; e2 = p2_i[31:16]; e3 = p3_i[31:16];
      end
      2'd2:    begin
        e0 = p0_i[47:32]; e1 = p1_i[47:32]; e2 = p2_i[47:32]; e3 = p3_i[47:32];
      end
      default: begin
        e0 = p0_i[15:0]; e1 = p1_i[15:0]; e2 = p2_i[15:0]; e3 = p3_i[15:0];
      end
    endcase
    ca = -20'(e0) + 20'sd3 * 20'(e1) - 20'sd3 * 20'(e2) + 20'(e3);
    cb = 20'sd3 * 20'(e0) - 20'sd6 * 20'(e1) + 20'sd3 * 20'(e2);
    cc = -20'sd3 * 20'(e0) + 20'sd3 * 20'(e1);
  end

  assign ts = $signed({1'b0, t_q});

  always_comb begin
    state_d = state_q;
    axis_d  = axis_q;
    acc_d   = acc_q;
    lo_d    = lo_q;
    res_d   = res_q;
    r       = '0;
    unique case (state_q)
      S_IDLE: begin
        axis_d = 2'd0;
        if (cmd_i.start) state_d = S_M1;
      end
      S_M1: begin
        // s2 = a*t + b*2^16
        acc_d   = 56'(a_q * ts) + (56'(b_q) <<< 16);
        state_d = S_M2;
      end
      S_M2: begin
        // s3 = s2*t + c*2^32, then split into hi/lo
        acc_d   = 56'(acc_q * 56'(ts)) + (56'(c_q) <<< 32);
        state_d = S_M3;
      end
      S_M3: begin
        lo_d    = acc_q[15:0];
        acc_d   = 56'(($signed(acc_q >>> 16)) * 56'(ts)) + (56'(d_q) <<< 32);
        state_d = S_M4;
      end
      S_M4: begin
        // fold in the low part, plus half an output step for round half up
        acc_d   = acc_q + $signed(56'((32'(lo_q) * 32'(t_q)) >> 16)) + (56'sd1 <<< 31);
        state_d = S_FIN;
      end
      S_FIN: begin
        r = acc_q >>> 32;
        if (r > 56'sd32767)       res_d[axis_q] = 16'sh7fff;
        else if (r < -56'sd32768) res_d[axis_q] = -16'sh8000;
        else                      res_d[axis_q] = r[15:0];
        if (axis_q == 2'd2) begin
          state_d = S_IDLE;
        end else begin
          axis_d  = axis_q + 2'd1;
          state_d = S_M1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      axis_q  <= 2'd0;
    end else begin
      state_q <= state_d;
      axis_q  <= axis_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && cmd_i.start) t_q <= cmd_i.t;
    if (state_q == S_IDLE || state_q == S_FIN) begin
      a_q <= ca;
      b_q <= cb;
      c_q <= cc;
      d_q <= e0;
    end
    acc_q <= acc_d;
    lo_q  <= lo_d;
    res_q <= res_d;
  end

  logic done_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else         done_q <= (state_q == S_FIN) && (axis_q == 2'd2);
  end

  assign rsp_o.done = done_q;
  assign rsp_o.x    = res_q[0];
  assign rsp_o.y    = res_q[1];
  assign rsp_o.z    = res_q[2];

`ifndef ASSERT_OFF
  a_axis_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    axis_q != 2'd3) else $error("axis counter out of range");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("done held");
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && cmd_i.start) |=> state_q == S_M1) else $error("start lost");
`endif
endmodule

>>> hdl/cubic_bezier_eval_and_project_unit.sv
// Cubic Bezier unit (3D). Evaluate: the result is offered once the shared evaluator has
// run five steps per axis (four dependent multiply stages and a round/saturate step)
// over three axes and raised done, and the output register has taken it. Project: a
// scan of SAMPLE_COUNT samples from the store, one read a cycle; after reset or a
// control-point write the first projection rebuilds the store first, one evaluation
// per sample. The next request is taken as soon as the unit is idle again; a result
// still waiting in the output register holds the unit only once the next result is due.
module cubic_bezier_eval_and_project_unit
  import cbe_pkg::*;
#(
  parameter int unsigned SAMPLE_COUNT = SampleCount
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [PointW-1:0]   cfg_data_i,
  cbe_stream_if.sink          req_if,
  cbe_stream_if.source        res_if
);
  localparam int unsigned AW = $clog2(SAMPLE_COUNT);
  // sample parameter steps: quotient and remainder of 2^16 / SAMPLE_COUNT
  localparam int unsigned TStep = (1 << TW) / SAMPLE_COUNT;
  localparam int unsigned RStep = (1 << TW) % SAMPLE_COUNT;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EVAL  = 3'd1;
  localparam logic [2:0] S_BUILD = 3'd2;
  localparam logic [2:0] S_BWAIT = 3'd3;
  localparam logic [2:0] S_SCAN  = 3'd4;
  localparam logic [2:0] S_DRAIN = 3'd5;
  localparam logic [2:0] S_PICK  = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [PointW-1:0] pt_q [NumPoints];
  logic stale_q;
  logic [2:0] state_q, state_d;
  req_t req_q;
  res_t res_q;
  logic res_vld_q;
  logic res_free;
  logic [AW:0] idx_q;      // issue counter, one wider to reach the count
  logic [AW-1:0] cmp_idx_q, best_idx_q;
  logic cmp_vld_q;
  logic [DistW-1:0] best_d_q;
  logic first_q;

  eval_cmd_t cmd;
  eval_rsp_t rsp;

  // sample parameter round(i*65536/N), halves up, kept as a running quotient and
  // remainder so no divider is needed
  logic [TW-1:0] tq_q;
  logic [AW-1:0] trem_q;
  logic [AW:0]   trem_sum;
  assign trem_sum = (AW+1)'(trem_q) + (AW+1)'(RStep);

  // output register is free when empty or being emptied this cycle
  assign res_free = !res_vld_q || res_if.ready;

  assign cmd.start = (state_q == S_BUILD) ||
                     (state_q == S_IDLE && req_if.valid &&
                      req_if.data.req_type == REQ_EVAL);
  assign cmd.t     = (state_q == S_BUILD) ? tq_q : req_if.data.t_param;

  cbe_eval u_eval (
    .clk_i, .rst_ni,
    .p0_i(pt_q[0]), .p1_i(pt_q[1]), .p2_i(pt_q[2]), .p3_i(pt_q[3]),
    .cmd_i(cmd), .rsp_o(rsp)
  );

  logic          we;
  logic [AW-1:0] raddr;
  logic [PointW-1:0] rdata;
  assign we    = (state_q == S_BWAIT) && rsp.done;
  // hold the winner's address while the result waits so the read data stays put
  assign raddr = (state_q == S_PICK || state_q == S_OUT) ? best_idx_q : idx_q[AW-1:0];

  cbe_ram #(.Width(PointW), .Depth(SAMPLE_COUNT)) u_store (
    .clk_i, .we_i(we), .waddr_i(idx_q[AW-1:0]),
    .wdata_i({rsp.z, rsp.y, rsp.x}), .raddr_i(raddr), .rdata_o(rdata)
  );

  assign req_if.ready = (state_q == S_IDLE);

  // distance of the read sample: squares registered, then summed
  logic signed [16:0] dx, dy, dz;
  logic [33:0] sx_q, sy_q, sz_q;
  logic sq_vld_q;
  logic [AW-1:0] sq_idx_q;
  logic [DistW-1:0] dsum;
  assign dx = 17'(signed'(rdata[15:0]))  - 17'(req_q.pos_x);
  assign dy = 17'(signed'(rdata[31:16])) - 17'(req_q.pos_y);
  assign dz = 17'(signed'(rdata[47:32])) - 17'(req_q.pos_z);
  assign dsum = DistW'(sx_q) + DistW'(sy_q) + DistW'(sz_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (req_if.valid) begin
        if (req_if.data.req_type == REQ_EVAL) state_d = S_EVAL;
        else if (stale_q)                     state_d = S_BUILD;
        else                                  state_d = S_SCAN;
      end
      S_EVAL:  if (rsp.done) state_d = S_OUT;
      S_BUILD: state_d = S_BWAIT;
      S_BWAIT: if (rsp.done) begin
        state_d = (idx_q == (AW+1)'(SAMPLE_COUNT - 1)) ? S_SCAN : S_BUILD;
      end
      S_SCAN:  if (idx_q == (AW+1)'(SAMPLE_COUNT - 1)) state_d = S_DRAIN;
      S_DRAIN: if (!cmp_vld_q && !sq_vld_q) state_d = S_PICK;
      S_PICK:  state_d = S_OUT;
      S_OUT:   if (res_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      stale_q   <= 1'b1;
      res_vld_q <= 1'b0;
      idx_q     <= '0;
      cmp_vld_q <= 1'b0;
      sq_vld_q  <= 1'b0;
      for (int i = 0; i < NumPoints; i++) pt_q[i] <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        pt_q[cfg_idx_i] <= cfg_data_i;
        stale_q         <= 1'b1;
      end else if (state_q == S_BWAIT && state_d == S_SCAN) begin
        stale_q <= 1'b0;
      end
      if (state_q == S_IDLE) idx_q <= '0;
      else if (state_q == S_BWAIT && rsp.done)
        idx_q <= (state_d == S_SCAN) ? '0 : idx_q + 1'b1;
      else if (state_q == S_SCAN) idx_q <= idx_q + 1'b1;
      cmp_vld_q <= (state_q == S_SCAN);
      sq_vld_q  <= cmp_vld_q;
      if (state_q == S_OUT && res_free) res_vld_q <= 1'b1;
      else if (res_if.ready)            res_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_if.valid && req_if.ready) begin
      req_q   <= req_if.data;
      first_q <= 1'b1;
    end
    // restart the sample parameter in idle, advance it per written sample
    if (state_q == S_IDLE) begin
      tq_q   <= '0;
      trem_q <= AW'(SAMPLE_COUNT / 2);
    end else if (state_q == S_BWAIT && rsp.done) begin
      if (trem_sum >= (AW+1)'(SAMPLE_COUNT)) begin
        tq_q   <= tq_q + TW'(TStep) + 1'b1;
        trem_q <= AW'(trem_sum - (AW+1)'(SAMPLE_COUNT));
      end else begin
        tq_q   <= tq_q + TW'(TStep);
        trem_q <= AW'(trem_sum);
      end
    end
    cmp_idx_q <= idx_q[AW-1:0];
    sq_idx_q  <= cmp_idx_q;
    sx_q <= 34'(dx * dx);
    sy_q <= 34'(dy * dy);
    sz_q <= 34'(dz * dz);
    if (sq_vld_q && (first_q || dsum < best_d_q)) begin
      best_d_q   <= dsum;
      best_idx_q <= sq_idx_q;
      first_q    <= 1'b0;
    end
    if (state_q == S_OUT && res_free) begin
      if (req_q.req_type == REQ_EVAL) begin
        res_q <= '{out_x: rsp.x, out_y: rsp.y, out_z: rsp.z,
                   sample_index: '0, distance_sq: '0};
      end else begin
        res_q <= '{out_x: rdata[15:0], out_y: rdata[31:16], out_z: rdata[47:32],
                   sample_index: IndexW'(best_idx_q), distance_sq: best_d_q};
      end
    end
  end

  assign res_if.valid = res_vld_q;
  assign res_if.data  = res_q;

`ifndef ASSERT_OFF
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !req_if.ready) else $error("accept while busy");
  a_scan_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> !stale_q || cfg_we_i || $past(cfg_we_i))
    else $error("scan of stale store");
  a_out_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT) |=> res_vld_q) else $error("result lost");
`endif
endmodule

>>> test/tb_cubic_bezier_eval_and_project_unit.sv
`timescale 1ns / 1ps

module tb_cubic_bezier_eval_and_project_unit;
  import cbe_pkg::*;

  localparam int unsigned WatchdogLimit = 20000;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [PointW-1:0] cfg_data_i;

  cbe_stream_if #(.T(req_t)) req_if ();
  cbe_stream_if #(.T(res_t)) res_if ();

  cubic_bezier_eval_and_project_unit uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req_if     (req_if),
    .res_if     (res_if)
  );

  // Predictor state: control points and the sample table
  logic [PointW-1:0] ctrl_pts [NumPoints];
  logic signed [CoordW-1:0] curve_tab [SampleCount][3];
  bit tab_stale;

  req_t pending_reqs[$];
  res_t expected_res[$];

  int send_idle_pct;
  int recv_stall_pct;
  int hold_off_cycles;
  int n_fail;
  int n_results;
  int n_eval;
  int n_proj;
  int quiet_cycles;

  // Round-to-nearest of the cubic at T/2^16, then saturate to 16 bits
  function automatic logic signed [CoordW-1:0] curve_axis(
      input longint p0, input longint p1, input longint p2, input longint p3,
      input longint t);
    longint ca, cb, cc, cd, s2, s3, hi, lo, q, x, r;
    ca = -p0 + 3 * p1 - 3 * p2 + p3;
    cb = 3 * p0 - 6 * p1 + 3 * p2;
    cc = -3 * p0 + 3 * p1;
    cd = p0;
    s2 = ca * t + cb * 65536;
    s3 = s2 * t + cc * 64'sd4294967296;
    hi = s3 >>> 16;
    lo = s3 - hi * 65536;
    q = hi * t + cd * 64'sd4294967296;
    x = q + ((lo * t + (64'sd1 <<< 47)) >>> 16);
    r = x >>> 32;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[CoordW-1:0];
  endfunction

  function automatic void curve_point(input logic [TW-1:0] t,
                                      output logic signed [CoordW-1:0] pt [3]);
    for (int k = 0; k < 3; k++) begin
      pt[k] = curve_axis(
        longint'($signed(ctrl_pts[0][16*k +: 16])), longint'($signed(ctrl_pts[1][16*k +: 16])),
        longint'($signed(ctrl_pts[2][16*k +: 16])), longint'($signed(ctrl_pts[3][16*k +: 16])),
        longint'(t));
    end
  endfunction

  function automatic res_t predict_result(input req_t rq);
    res_t rs;
    logic signed [CoordW-1:0] pt [3];
    longint best_d, sq_dist, df;
    int best_i;
    best_i = 0;
    best_d = 0;
    if (rq.req_type == REQ_EVAL) begin
      curve_point(rq.t_param, pt);
    end else begin
      if (tab_stale) begin
        for (int i = 0; i < SampleCount; i++) begin
          curve_point(TW'((i * 65536 + SampleCount / 2) / SampleCount), pt);
          for (int k = 0; k < 3; k++) curve_tab[i][k] = pt[k];
        end
        tab_stale = 0;
      end
      for (int i = 0; i < SampleCount; i++) begin
        sq_dist = 0;
        for (int k = 0; k < 3; k++) begin
          df = longint'(curve_tab[i][k]) - longint'(k == 0 ? rq.pos_x :
                                                     k == 1 ? rq.pos_y : rq.pos_z);
          sq_dist += df * df;
        end
        if (i == 0 || sq_dist < best_d) begin
          best_d = sq_dist;
          best_i = i;
        end
      end
      for (int k = 0; k < 3; k++) pt[k] = curve_tab[best_i][k];
    end
    rs.out_x = pt[0];
    rs.out_y = pt[1];
    rs.out_z = pt[2];
    rs.sample_index = IndexW'(best_i);
    rs.distance_sq = DistW'(best_d);
    return rs;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Driver: offer the head of the queue, idle at random between transfers
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      req_if.data <= '0;
    end else if (!req_if.valid || req_if.ready) begin
      if (req_if.valid) void'(pending_reqs.pop_front());
      if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        req_if.valid <= 1'b1;
        req_if.data <= pending_reqs[0];
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // Monitor: predict at request transfer, check at result transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) begin
        expected_res.push_back(predict_result(req_if.data));
        if (req_if.data.req_type == REQ_EVAL) n_eval++;
        else n_proj++;
      end
      if (res_if.valid && res_if.ready) begin
        if (expected_res.size() == 0) begin
          $error("result with nothing expected: %p", res_if.data);
          n_fail++;
        end else begin
          res_t want;
          want = expected_res.pop_front();
          if (res_if.data.out_x !== want.out_x) begin
            $error("out_x expected %0d got %0d", want.out_x, res_if.data.out_x); n_fail++;
          end
          if (res_if.data.out_y !== want.out_y) begin
            $error("out_y expected %0d got %0d", want.out_y, res_if.data.out_y); n_fail++;
          end
          if (res_if.data.out_z !== want.out_z) begin
            $error("out_z expected %0d got %0d", want.out_z, res_if.data.out_z); n_fail++;
          end
          if (res_if.data.sample_index !== want.sample_index) begin
            $error("sample_index expected %0d got %0d", want.sample_index,
                   res_if.data.sample_index); n_fail++;
          end
          if (res_if.data.distance_sq !== want.distance_sq) begin
            $error("distance_sq expected %0d got %0d", want.distance_sq,
                   res_if.data.distance_sq); n_fail++;
          end
        end
        n_results++;
      end
      // Ready for next edge; a long hold-off takes priority over random stalls
      if (hold_off_cycles > 0) begin
        hold_off_cycles <= hold_off_cycles - 1;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog: count cycles without any transfer
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready) || hold_off_cycles > 0)
      quiet_cycles <= 0;
    else if (pending_reqs.size() > 0 || expected_res.size() > 0)
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("timeout with %0d items pending, %0d results owed",
               pending_reqs.size(), expected_res.size());
      $display("Verification failed");
      $finish;
    end
  end

  function automatic logic signed [CoordW-1:0] rand_coord();
    case ($urandom_range(5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return CoordW'($urandom_range(0, 200)) - 16'sd100;
      default: return CoordW'($urandom);
    endcase
  endfunction

  function automatic req_t rand_req();
    req_t rq;
    rq.req_type = 1'($urandom_range(1));
    rq.t_param = ($urandom_range(7) == 0) ? (($urandom_range(1)) ? 16'hffff : 16'h0)
                                           : TW'($urandom);
    rq.pos_x = rand_coord();
    rq.pos_y = rand_coord();
    rq.pos_z = rand_coord();
    return rq;
  endfunction

  function automatic req_t make_req(input logic kind, input logic [TW-1:0] t,
                                    input logic [CoordW-1:0] px,
                                    input logic [CoordW-1:0] py,
                                    input logic [CoordW-1:0] pz);
    req_t rq;
    rq.req_type = kind;
    rq.t_param = t;
    rq.pos_x = px;
    rq.pos_y = py;
    rq.pos_z = pz;
    return rq;
  endfunction

  // Write one control point at an edge; only while the unit is idle
  task automatic write_point(input int idx, input logic [PointW-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CfgIdxW'(idx);
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    ctrl_pts[idx] = val;
    tab_stale = 1;
  endtask

  task automatic drain();
    wait (pending_reqs.size() == 0 && !req_if.valid && expected_res.size() == 0);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_all_points(input int mode);
    for (int i = 0; i < NumPoints; i++) begin
      logic [PointW-1:0] v;
      case (mode)
        0: v = PointW'({$urandom, $urandom});
        1: v = {3{(i % 2) ? 16'h7fff : 16'h8000}};
        2: v = {3{(i % 2) ? 16'h8000 : 16'h7fff}};
        default: v = {CoordW'($urandom_range(0, 2000)) - 16'sd1000,
                      CoordW'($urandom_range(0, 2000)) - 16'sd1000,
                      CoordW'($urandom_range(0, 2000)) - 16'sd1000};
      endcase
      write_point(i, v);
    end
  endtask

  task automatic push_random(input int n);
    for (int i = 0; i < n; i++) pending_reqs.push_back(rand_req());
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    req_if.valid = 1'b0;
    req_if.data = '0;
    res_if.ready = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off_cycles = 0;
    n_fail = 0;
    n_results = 0;
    n_eval = 0;
    n_proj = 0;
    quiet_cycles = 0;
    for (int i = 0; i < NumPoints; i++) ctrl_pts[i] = '0;
    tab_stale = 1;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: all-zero curve first, projection straight after reset
    pending_reqs.push_back(make_req(REQ_PROJECT, 16'h0, 16'h0, 16'h0, 16'h0));
    pending_reqs.push_back(make_req(REQ_EVAL, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff));
    drain();
    // Extreme alternating points put the cubic at the edges of the 16-bit range
    write_all_points(1);
    pending_reqs.push_back(make_req(REQ_EVAL, 16'h0000, 16'h0, 16'h0, 16'h0));
    pending_reqs.push_back(make_req(REQ_EVAL, 16'h0001, 16'hffff, 16'hffff, 16'hffff));
    pending_reqs.push_back(make_req(REQ_EVAL, 16'h5555, 16'h0, 16'h0, 16'h0));
    pending_reqs.push_back(make_req(REQ_EVAL, 16'h8000, 16'h0, 16'h0, 16'h0));
    pending_reqs.push_back(make_req(REQ_EVAL, 16'hffff, 16'h0, 16'h0, 16'h0));
    pending_reqs.push_back(make_req(REQ_PROJECT, 16'hffff, 16'h7fff, 16'h7fff, 16'h7fff));
    pending_reqs.push_back(make_req(REQ_PROJECT, 16'h0, 16'h8000, 16'h8000, 16'h8000));
    pending_reqs.push_back(make_req(REQ_PROJECT, 16'h0, 16'h0, 16'h0, 16'h0));
    drain();
    write_all_points(2);
    pending_reqs.push_back(make_req(REQ_EVAL, 16'h8000, 16'h0, 16'h0, 16'h0));
    pending_reqs.push_back(make_req(REQ_PROJECT, 16'h0, 16'h7fff, 16'h8000, 16'h0));
    drain();
    // Equal-distance case: a straight flat curve and a point on the axis of symmetry
    write_point(0, {16'h0, 16'h0, 16'hfc00});
    write_point(1, {16'h0, 16'h0, 16'hfe00});
    write_point(2, {16'h0, 16'h0, 16'h0200});
    write_point(3, {16'h0, 16'h0, 16'h0400});
    pending_reqs.push_back(make_req(REQ_PROJECT, 16'h0, 16'h0, 16'h0, 16'h0));
    pending_reqs.push_back(make_req(REQ_PROJECT, 16'h0, 16'h0, 16'h0100, 16'h0));
    pending_reqs.push_back(make_req(REQ_EVAL, 16'h4000, 16'h0, 16'h0, 16'h0));
    drain();

    // Random phases, each with its own curve and idling pattern
    for (int ph = 0; ph < 8; ph++) begin
      write_all_points(ph % 4 == 1 ? 3 : (ph == 2 ? 1 : 0));
      case (ph % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 52; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 52; end
        default: begin send_idle_pct = 28; recv_stall_pct = 28; end
      endcase
      if (ph == 4) begin
        // Stall the result side long enough for the input to back up
        hold_off_cycles = 300;
        send_idle_pct = 0;
      end
      push_random(178);
      if (ph == 6) begin
        // Pause the sender until everything is back, then carry on
        wait (pending_reqs.size() == 0 && expected_res.size() == 0);
        push_random(10);
      end
      drain();
    end

    $display("Covered %0d evaluations and %0d projections over several curves and idling mixes",
             n_eval, n_proj);
    $display("%0d results checked", n_results);
    if (n_fail == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
